/* hw/rtl/bsp_pkg.sv */
// Shared types and constants for the binomial smoothing block.
// Used by bsp_div, bsp_pass and the top module; depends on nothing else.
`timescale 1ns / 1ps

package bsp_pkg;

   // Sample format: signed fixed point with 8 fraction bits.
   localparam int SAMPLE_W = 32;

   // Filter shape: 11 symmetric taps, weights total 1024.
   localparam int HALF_TAPS = 5;
   localparam int TAPS      = 2 * HALF_TAPS + 1;
   localparam int WSUM_W    = 11;
   localparam int WSHIFT    = 10;
   localparam logic [WSUM_W-1:0] FULL_WSUM = WSUM_W'(1024);
   localparam logic [7:0] TAP_WEIGHT [HALF_TAPS+1] = '{8'd252, 8'd210, 8'd120,
                                                       8'd45, 8'd10, 8'd1};

   // Accumulator and divider widths.
   localparam int ACC_W     = 44;
   localparam int DIV_NUM_W = 44;
   localparam int DIV_DEN_W = WSUM_W + 1;

   // Pass count register.
   localparam int PASS_W = 16;
   localparam logic [PASS_W-1:0] PASS_COUNT_RESET = 16'd10000;

   // Item operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       load_last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smoothed;
      logic                       read_last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic flip;
      logic done;
   } pass_ctl_type;

endpackage

/* hw/rtl/bsp_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing else.
`timescale 1ns / 1ps

module bsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data holds while the read enable is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bsp_div.sv */
// Restoring divider, one quotient bit per cycle, for the rounded edge averages.
// Depends on bsp_pkg.
`timescale 1ns / 1ps

module bsp_div
   import bsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIV_NUM_W-1:0]  num,
   input  logic [DIV_DEN_W-1:0]  den,
   output div_status_type        status,
   output logic [SAMPLE_W-1:0]   quot
);

   localparam int CW = $clog2(DIV_NUM_W + 1);

   typedef enum logic [1:0] {DV_IDLE, DV_BUSY, DV_DONE} div_state_type;

   div_state_type        state_ff;
   logic [CW-1:0]        count_ff;
   logic [DIV_NUM_W-1:0] work_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   // One trial subtraction per cycle; the remainder always stays below den.
   always_comb begin
      trial = {rem_ff, work_ff[DIV_NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  state_ff <= DV_BUSY;
                  count_ff <= '0;
                  work_ff  <= num;
                  rem_ff   <= '0;
                  den_ff   <= den;
               end
            end
            DV_BUSY: begin
               rem_ff   <= ge ? DIV_DEN_W'(trial - {1'b0, den_ff}) : DIV_DEN_W'(trial);
               work_ff  <= {work_ff[DIV_NUM_W-2:0], ge};
               count_ff <= count_ff + 1'b1;
               if (count_ff == CW'(DIV_NUM_W - 1)) begin
                  state_ff <= DV_DONE;
               end
            end
            DV_DONE: begin
               state_ff <= DV_IDLE;
            end
            default: begin
               state_ff <= DV_IDLE;
            end
         endcase
      end
   end

   assign status.busy = (state_ff == DV_BUSY);
   assign status.done = (state_ff == DV_DONE);
   assign quot        = work_ff[SAMPLE_W-1:0];

endmodule

/* hw/rtl/bsp_pass.sv */
// Smoothing pass engine: streams the source buffer through an 11-tap window
// and writes the rounded averages to the destination buffer.
// Depends on bsp_pkg and bsp_div.
`timescale 1ns / 1ps

module bsp_pass
   import bsp_pkg::*;
#(
   parameter int MAX_LENGTH = 1024,
   localparam int AW        = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
   localparam int LEN_W     = $clog2(MAX_LENGTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [LEN_W-1:0]    length,
   input  logic [PASS_W-1:0]   pass_count,
   output pass_ctl_type        ctl,
   output logic [AW-1:0]       rd_addr,
   input  logic [SAMPLE_W-1:0] rd_data,
   output logic [AW-1:0]       wr_addr,
   output logic [SAMPLE_W-1:0] wr_data
);

   localparam int SW = $clog2(MAX_LENGTH + HALF_TAPS + 1);

   typedef enum logic {PS_IDLE, PS_RUN} pass_state_type;

   pass_state_type state_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [PASS_W-1:0] pass_idx_ff;
   logic [SW-1:0]     step_ff;
   logic              changed_ff;
   logic              done_ff;

   // Read stage.
   logic          s1_vld_ff;
   logic          s1_real_ff;
   logic [SW-1:0] s1_step_ff;

   // Window stage.
   logic signed [SAMPLE_W-1:0] win_ff [TAPS];
   logic [TAPS-1:0]            wvld_ff;
   logic                       win_go_ff;
   logic [AW-1:0]              win_idx_ff;

   // Weighted term stage.
   logic signed [ACC_W-1:0]    term_ff [HALF_TAPS+1];
   logic [WSUM_W-1:0]          wpart_ff [HALF_TAPS+1];
   logic                       st2_vld_ff;
   logic [AW-1:0]              st2_idx_ff;
   logic signed [SAMPLE_W-1:0] st2_ctr_ff;

   // Sum stage.
   logic signed [ACC_W-1:0]    st3_acc_ff;
   logic [WSUM_W-1:0]          st3_wsum_ff;
   logic                       st3_vld_ff;
   logic [AW-1:0]              st3_idx_ff;
   logic signed [SAMPLE_W-1:0] st3_ctr_ff;

   logic signed [ACC_W-1:0] tap_val [TAPS];
   logic signed [ACC_W-1:0] pair_v  [HALF_TAPS+1];
   logic signed [ACC_W-1:0] term_in [HALF_TAPS+1];
   logic [WSUM_W-1:0]       wpart_in [HALF_TAPS+1];
   logic signed [ACC_W-1:0] acc_in;
   logic [WSUM_W-1:0]       wsum_in;

   logic                  running, issue, issue_real, hold, need_div, wb_fire;
   logic                  last_wb, changed_now;
   logic                  neg;
   logic [ACC_W-1:0]      mag, round_sum;
   logic [SAMPLE_W-1:0]   qmag, res;
   logic [DIV_NUM_W-1:0]  div_num;
   logic [DIV_DEN_W-1:0]  div_den;
   logic                  div_start;
   div_status_type        div_st;
   logic [SAMPLE_W-1:0]   div_q;

   // Masked taps, symmetric pair sums and their weights.
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         tap_val[i] = wvld_ff[i] ? ACC_W'(win_ff[i]) : '0;
      end
      for (int k = 0; k <= HALF_TAPS; k++) begin
         pair_v[k]   = (k == 0) ? tap_val[HALF_TAPS]
                                : tap_val[HALF_TAPS-k] + tap_val[HALF_TAPS+k];
         term_in[k]  = pair_v[k] * $signed({1'b0, TAP_WEIGHT[k]});
         wpart_in[k] = (wvld_ff[HALF_TAPS-k] ? WSUM_W'(TAP_WEIGHT[k]) : '0)
                     + ((k != 0) && wvld_ff[HALF_TAPS+k] ? WSUM_W'(TAP_WEIGHT[k]) : '0);
      end
   end

   // Sum of the six weighted terms and of the weights that remain.
   always_comb begin
      acc_in  = '0;
      wsum_in = '0;
      for (int k = 0; k <= HALF_TAPS; k++) begin
         acc_in  = acc_in + term_ff[k];
         wsum_in = wsum_in + wpart_ff[k];
      end
   end

   // Rounding: a shift for the full weight total, the divider near the ends.
   always_comb begin
      neg       = st3_acc_ff[ACC_W-1];
      mag       = neg ? ACC_W'(-st3_acc_ff) : ACC_W'(st3_acc_ff);
      round_sum = mag + ACC_W'(FULL_WSUM >> 1);
      div_num   = DIV_NUM_W'({mag, 1'b0}) + DIV_NUM_W'(st3_wsum_ff);
      div_den   = {st3_wsum_ff, 1'b0};
      need_div  = st3_vld_ff && (st3_wsum_ff != FULL_WSUM);
      hold      = need_div && !div_st.done;
      div_start = need_div && !div_st.busy && !div_st.done;
      wb_fire   = st3_vld_ff && !hold;
      qmag      = need_div ? div_q : round_sum[WSHIFT +: SAMPLE_W];
      res       = neg ? SAMPLE_W'(-qmag) : qmag;
   end

   // Read issue and pass end.
   always_comb begin
      running     = (state_ff == PS_RUN);
      issue       = running && !hold && (step_ff < SW'(len_ff) + SW'(HALF_TAPS));
      issue_real  = step_ff < SW'(len_ff);
      last_wb     = wb_fire && (LEN_W'(st3_idx_ff) == len_ff - 1'b1);
      changed_now = changed_ff || (res != st3_ctr_ff);
   end

   bsp_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_st),
      .quot   (div_q)
   );

   // Sequencer and pipeline registers; every stage freezes while the divider works.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PS_IDLE;
         done_ff     <= 1'b0;
         changed_ff  <= 1'b0;
         step_ff     <= '0;
         pass_idx_ff <= '0;
         s1_vld_ff   <= 1'b0;
         wvld_ff     <= '0;
         win_go_ff   <= 1'b0;
         st2_vld_ff  <= 1'b0;
         st3_vld_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;

         if (!hold) begin
            s1_vld_ff  <= issue;
            s1_real_ff <= issue_real;
            s1_step_ff <= step_ff;
            if (issue) begin
               step_ff <= step_ff + 1'b1;
            end

            if (s1_vld_ff) begin
               for (int i = 0; i < TAPS - 1; i++) begin
                  win_ff[i] <= win_ff[i+1];
               end
               win_ff[TAPS-1] <= rd_data;
               wvld_ff        <= {s1_real_ff, wvld_ff[TAPS-1:1]};
               win_go_ff      <= s1_step_ff >= SW'(HALF_TAPS);
               win_idx_ff     <= AW'(s1_step_ff - SW'(HALF_TAPS));
            end else begin
               win_go_ff <= 1'b0;
            end

            st2_vld_ff <= win_go_ff;
            st2_idx_ff <= win_idx_ff;
            st2_ctr_ff <= win_ff[HALF_TAPS];
            for (int k = 0; k <= HALF_TAPS; k++) begin
               term_ff[k]  <= term_in[k];
               wpart_ff[k] <= wpart_in[k];
            end

            st3_vld_ff  <= st2_vld_ff;
            st3_idx_ff  <= st2_idx_ff;
            st3_ctr_ff  <= st2_ctr_ff;
            st3_acc_ff  <= acc_in;
            st3_wsum_ff <= wsum_in;
         end

         if (wb_fire) begin
            changed_ff <= changed_now;
         end

         case (state_ff)
            PS_IDLE: begin
               if (start) begin
                  len_ff      <= length;
                  pass_idx_ff <= '0;
                  step_ff     <= '0;
                  changed_ff  <= 1'b0;
                  wvld_ff     <= '0;
                  if (pass_count == '0) begin
                     done_ff <= 1'b1;
                  end else begin
                     state_ff <= PS_RUN;
                  end
               end
            end
            PS_RUN: begin
               if (last_wb) begin
                  if (!changed_now || (pass_idx_ff + 1'b1 == pass_count)) begin
                     state_ff <= PS_IDLE;
                     done_ff  <= 1'b1;
                  end else begin
                     pass_idx_ff <= pass_idx_ff + 1'b1;
                     step_ff     <= '0;
                     changed_ff  <= 1'b0;
                     s1_vld_ff   <= 1'b0;
                     wvld_ff     <= '0;
                     win_go_ff   <= 1'b0;
                     st2_vld_ff  <= 1'b0;
                     st3_vld_ff  <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= PS_IDLE;
            end
         endcase
      end
   end

   assign ctl.rd_en = issue && issue_real;
   assign ctl.wr_en = wb_fire;
   assign ctl.flip  = last_wb && changed_now;
   assign ctl.done  = done_ff;
   assign rd_addr   = step_ff[AW-1:0];
   assign wr_addr   = st3_idx_ff;
   assign wr_data   = res;

endmodule

/* hw/rtl/binomial_smoothing_passes.sv */
// Binomial smoothing block: load a vector, run pass_count 11-tap smoothing
// passes between two sample buffers, then read the result back in order.
// Depends on bsp_pkg, bsp_ram and bsp_pass.
//
// Usage: a load item writes its sample into the buffer when it is accepted; a read
// item passes through the registered read of the sample buffer, then the result register.
// The load marked last starts the passes, during which no item is accepted.
// Each pass streams the vector through the window once from one buffer into
// the other, stalling in the shared divider for each sample whose taps run
// past an end of the vector (up to ten samples per pass, every sample of a
// vector shorter than 11). Passes stop early once a pass leaves every sample
// unchanged. The buffers need no clearing after reset.
`timescale 1ns / 1ps

module binomial_smoothing_passes
   import bsp_pkg::*;
#(
   parameter int MAX_LENGTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_payload,
   input  logic              csr_wr_en,
   input  logic [PASS_W-1:0] csr_wr_data
);

   localparam int AW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int LEN_W = $clog2(MAX_LENGTH + 1);

   logic [PASS_W-1:0] pass_count_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  rpos_ff;
   logic              done_ff;
   logic              bank_ff;
   logic              busy_ff;
   logic              start_ff;
   logic              pend_ff;
   logic              pend_last_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic             req_acc, load_acc, read_acc, read_fire;
   logic [LEN_W-1:0] eff_len, rpos_now;
   logic             load_wr, rd_is_last;

   pass_ctl_type      pe_ctl;
   logic [AW-1:0]     pe_rd_addr, pe_wr_addr;
   logic [SAMPLE_W-1:0] pe_wr_data, pe_rd_data;

   logic                even_wr_en, odd_wr_en, even_rd_en, odd_rd_en;
   logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
   logic [SAMPLE_W-1:0] mem_wr_data, even_q, odd_q;

   // Item acceptance and decode.
   always_comb begin
      req_stall  = busy_ff || pend_ff || (rsp_valid_ff && rsp_stall);
      req_acc    = req_valid && !req_stall;
      load_acc   = req_acc && (req_payload.op == OP_LOAD);
      read_acc   = req_acc && (req_payload.op == OP_READ);
      read_fire  = read_acc && done_ff && (len_ff != '0);
      eff_len    = done_ff ? '0 : len_ff;
      load_wr    = load_acc && (eff_len < LEN_W'(MAX_LENGTH));
      rpos_now   = (rpos_ff >= len_ff) ? '0 : rpos_ff;
      rd_is_last = (rpos_now + 1'b1 == len_ff);
   end

   // Buffer ports: the pass engine owns them while busy, items otherwise.
   always_comb begin
      even_wr_en  = busy_ff ? (pe_ctl.wr_en && bank_ff) : load_wr;
      odd_wr_en   = busy_ff && pe_ctl.wr_en && !bank_ff;
      mem_wr_addr = busy_ff ? pe_wr_addr : eff_len[AW-1:0];
      mem_wr_data = busy_ff ? pe_wr_data : req_payload.sample_in;
      even_rd_en  = busy_ff ? (pe_ctl.rd_en && !bank_ff) : (read_fire && !bank_ff);
      odd_rd_en   = busy_ff ? (pe_ctl.rd_en && bank_ff) : (read_fire && bank_ff);
      mem_rd_addr = busy_ff ? pe_rd_addr : rpos_now[AW-1:0];
      pe_rd_data  = bank_ff ? odd_q : even_q;
   end

   bsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_buf_even (
      .clock   (clock),
      .wr_en   (even_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (even_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (even_q)
   );

   bsp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_buf_odd (
      .clock   (clock),
      .wr_en   (odd_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (odd_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (odd_q)
   );

   bsp_pass #(.MAX_LENGTH(MAX_LENGTH)) u_pass (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .length     (len_ff),
      .pass_count (pass_count_ff),
      .ctl        (pe_ctl),
      .rd_addr    (pe_rd_addr),
      .rd_data    (pe_rd_data),
      .wr_addr    (pe_wr_addr),
      .wr_data    (pe_wr_data)
   );

   // Vector bookkeeping, configuration and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pass_count_ff <= PASS_COUNT_RESET;
         len_ff        <= '0;
         rpos_ff       <= '0;
         done_ff       <= 1'b0;
         bank_ff       <= 1'b0;
         busy_ff       <= 1'b0;
         start_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_ff <= 1'b0;

         if (csr_wr_en) begin
            pass_count_ff <= csr_wr_data;
         end

         if (load_acc) begin
            if (eff_len == '0) begin
               bank_ff <= 1'b0;
            end
            len_ff  <= load_wr ? eff_len + 1'b1 : eff_len;
            rpos_ff <= '0;
            done_ff <= req_payload.load_last;
            if (req_payload.load_last) begin
               busy_ff  <= 1'b1;
               start_ff <= 1'b1;
            end
         end

         if (pe_ctl.flip) begin
            bank_ff <= !bank_ff;
         end
         if (pe_ctl.done) begin
            busy_ff <= 1'b0;
         end

         // A read moves through the buffer, then into the result register.
         pend_ff <= read_fire;
         if (read_fire) begin
            pend_last_ff <= rd_is_last;
            rpos_ff      <= rd_is_last ? '0 : rpos_now + 1'b1;
         end
         if (pend_ff) begin
            rsp_valid_ff       <= 1'b1;
            rsp_ff.smoothed    <= bank_ff ? odd_q : even_q;
            rsp_ff.read_last   <= pend_last_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The pass engine never touches the buffers while an item is taken.
   a_no_item_during_pass: assert property (@(posedge clock) disable iff (reset)
      (pe_ctl.wr_en || pe_ctl.rd_en) |-> !req_acc)
      else $error("buffer access by the pass engine while an item was accepted");

   // A result is raised only from a pending buffer read, through the result register.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pend_ff))
      else $error("result shown without a preceding buffer read");

   // The odd buffer holds the current data only for a completed vector.
   a_bank_done: assert property (@(posedge clock) disable iff (reset)
      bank_ff |-> done_ff)
      else $error("odd buffer selected for an incomplete vector");

endmodule
